// ----- sv/cia_pkg.sv -----
`timescale 1ns / 1ps
package cia_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cia_op_e;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned InDataWidth = 136;
  localparam int unsigned OutDataWidth = 72;

  // side data that rides alongside the divider
  typedef struct packed {
    cia_op_e                op;
    logic                   zero_div;
    logic                   neg_r;
    logic                   neg_i;
    logic [FieldWidth-1:0]  res_real;
    logic [FieldWidth-1:0]  res_imag;
  } cia_side_t;

endpackage

// ----- sv/cia_div.sv -----
`timescale 1ns / 1ps
module cia_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] quot_o
);

  logic [W-1:0] rem_q [W];
  logic [W-1:0] num_q [W];
  logic [W-1:0] den_q [W];

  // one restoring step per stage, msb first
  for (genvar g = 0; g < W; g++) begin : g_stage
    logic [W-1:0] rin, nin, din;
    logic [W:0]   trial, diff;
    logic         ge;
    if (g == 0) begin : g_first
      assign rin = '0;
      assign nin = num_i;
      assign din = den_i;
    end else begin : g_next
      assign rin = rem_q[g-1];
      assign nin = num_q[g-1];
      assign din = den_q[g-1];
    end
    assign trial = {rin, nin[W-1]};
    assign diff  = trial - {1'b0, din};
    assign ge    = trial >= {1'b0, din};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= ge ? diff[W-1:0] : trial[W-1:0];
        num_q[g] <= {nin[W-2:0], ge};
        den_q[g] <= din;
      end
    end
  end

  assign quot_o = num_q[W-1];

endmodule

// ----- sv/complex_integer_alu.sv -----
`timescale 1ns / 1ps
// path: an item passes stages 1 to 3, the divider stages and the output register
// throughput: one item per cycle unless the output stalls; set by the fully pipelined
// multipliers and the divider, which spends one register stage per quotient bit
// reset: asynchronous active-low rst_ni clears all valid bits, so no result is
// shown until a new item arrives; payload registers are not reset
module complex_integer_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // opcode[1:0], a_real[33:2], a_imag[65:34], b_real[97:66], b_imag[129:98], zero fill
  input  logic [cia_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // res_real[31:0], res_imag[63:32], zero_divisor[64], zero fill
  output logic [cia_pkg::OutDataWidth-1:0] m_axis_tdata_o
);
  import cia_pkg::*;

  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned F = FieldWidth;
  localparam int unsigned Depth = W + 3;

  // whole pipeline advances together when the output register is free
  logic en;
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  logic [Depth-1:0] vld_q;
  logic             out_vld_q;

  // sign-extend the 32-bit fields and wrap them to the datapath width
  logic [W-1:0] ar, ai, br, bi;
  logic [W+F-1:0] ext_ar, ext_ai, ext_br, ext_bi;
  cia_op_e in_op;
  assign in_op  = cia_op_e'(s_axis_tdata_i[1:0]);
  assign ext_ar = {{W{s_axis_tdata_i[33]}}, s_axis_tdata_i[33:2]};
  assign ext_ai = {{W{s_axis_tdata_i[65]}}, s_axis_tdata_i[65:34]};
  assign ext_br = {{W{s_axis_tdata_i[97]}}, s_axis_tdata_i[97:66]};
  assign ext_bi = {{W{s_axis_tdata_i[129]}}, s_axis_tdata_i[129:98]};
  assign ar = ext_ar[W-1:0];
  assign ai = ext_ai[W-1:0];
  assign br = ext_br[W-1:0];
  assign bi = ext_bi[W-1:0];

  // stage 1: all products, plus add/subtract
  logic [W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_cc_q, as_r_q, as_i_q;
  cia_op_e op1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= in_op;
      p_rr_q <= ar * br;
      p_ii_q <= ai * bi;
      p_ri_q <= ar * bi;
      p_ir_q <= ai * br;
      p_bb_q <= br * br;
      p_cc_q <= bi * bi;
      as_r_q <= (in_op == OP_SUB) ? ar - br : ar + br;
      as_i_q <= (in_op == OP_SUB) ? ai - bi : ai + bi;
    end
  end

  // stage 2: cross sums and squared magnitude
  logic [W-1:0] nr_q, ni_q, d_q, r2_q, i2_q;
  cia_op_e op2_q;
  logic [W-1:0] d_sum;
  assign d_sum = p_bb_q + p_cc_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q <= op1_q;
      nr_q  <= p_rr_q + p_ii_q;
      ni_q  <= p_ir_q - p_ri_q;
      d_q   <= d_sum;
      r2_q  <= (op1_q == OP_MUL) ? p_rr_q - p_ii_q : as_r_q;
      i2_q  <= (op1_q == OP_MUL) ? p_ri_q + p_ir_q : as_i_q;
    end
  end

  // stage 3: magnitudes and signs for the divider
  logic [W-1:0] mag_nr_q, mag_ni_q, mag_d_q;
  cia_side_t side3_q;
  logic nr_neg, ni_neg, d_neg;
  logic [W+F-1:0] r2_ext, i2_ext;
  assign nr_neg = nr_q[W-1];
  assign ni_neg = ni_q[W-1];
  assign d_neg  = d_q[W-1];
  assign r2_ext = {{F{1'b0}}, r2_q};
  assign i2_ext = {{F{1'b0}}, i2_q};
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_nr_q          <= nr_neg ? -nr_q : nr_q;
      mag_ni_q          <= ni_neg ? -ni_q : ni_q;
      mag_d_q           <= d_neg ? -d_q : d_q;
      side3_q.op        <= op2_q;
      side3_q.zero_div  <= (op2_q == OP_DIV) && (d_q == '0);
      side3_q.neg_r     <= nr_neg ^ d_neg;
      side3_q.neg_i     <= ni_neg ^ d_neg;
      side3_q.res_real  <= r2_ext[F-1:0];
      side3_q.res_imag  <= i2_ext[F-1:0];
    end
  end

  // two dividers share the divisor magnitude
  logic [W-1:0] quot_r, quot_i;
  cia_div #(.W(W)) u_div_real (
    .clk_i (clk_i), .en_i (en), .num_i (mag_nr_q), .den_i (mag_d_q), .quot_o (quot_r)
  );
  cia_div #(.W(W)) u_div_imag (
    .clk_i (clk_i), .en_i (en), .num_i (mag_ni_q), .den_i (mag_d_q), .quot_o (quot_i)
  );

  // side data delay matched to the divider
  cia_side_t side_q [W];
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side3_q;
      for (int unsigned k = 1; k < W; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Depth-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  // output register: pick quotient, zero for a zero divisor, or passed-through result
  cia_side_t last;
  logic [W-1:0] q_r, q_i;
  logic [W+F-1:0] q_r_ext, q_i_ext;
  assign last    = side_q[W-1];
  assign q_r     = last.neg_r ? -quot_r : quot_r;
  assign q_i     = last.neg_i ? -quot_i : quot_i;
  assign q_r_ext = {{F{1'b0}}, q_r};
  assign q_i_ext = {{F{1'b0}}, q_i};

  logic [F-1:0] res_r_q, res_i_q;
  logic         zero_q;
  cia_op_e      out_op_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_op_q <= last.op;
      zero_q   <= last.zero_div;
      if (last.op != OP_DIV) begin
        res_r_q <= last.res_real;
        res_i_q <= last.res_imag;
      end else if (last.zero_div) begin
        res_r_q <= '0;
        res_i_q <= '0;
      end else begin
        res_r_q <= q_r_ext[F-1:0];
        res_i_q <= q_i_ext[F-1:0];
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, zero_q, res_i_q, res_r_q};

  // zero divisor only flagged for divide
  a_flag_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && zero_q |-> out_op_q == OP_DIV)
    else $error("zero divisor flag on non-divide");

  // zero divisor gives zero parts
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && zero_q |-> res_r_q == '0 && res_i_q == '0)
    else $error("zero divisor with nonzero result");

  // a stalled result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule
